### sv/sata_pkg.sv
// Types, constants and codes shared by the set-associative table modules.
`timescale 1ns / 1ps
package sata_pkg;

  localparam int SET_W     = 16;
  localparam int SET_COUNT = 1 << SET_W;
  localparam int WAY_COUNT = 3;
  localparam int WAY_W     = 2;
  localparam int TAG_W     = 32;
  localparam int KEY_W     = 64;
  localparam int GEN_W     = 8;
  localparam int PROOF_W   = 27;
  localparam int DIST_W    = 20;
  localparam int VISITS_W  = 31;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIST_W-1:0] DEFAULT_DISTANCE = DIST_W'(1000000);
  localparam logic [PROOF_W-1:0] DEFAULT_PROOF   = PROOF_W'(1);
  localparam logic [WAY_W:0] WAY_LIMIT           = (WAY_W + 1)'(WAY_COUNT);

  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MASK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATION = CFG_IDX_W'(1);

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_WRITE  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_FILL    = 2'd1,
    OUT_REPLACE = 2'd2,
    OUT_WRITE   = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [GEN_W-1:0]    age;
    logic [PROOF_W-1:0]  proof;
    logic [PROOF_W-1:0]  disproof;
    logic [DIST_W-1:0]   distance;
    logic [VISITS_W-1:0] visits;
  } entry_t;

  typedef entry_t [WAY_COUNT-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    action_e             action;
    logic [TAG_W-1:0]    tag;
    logic [WAY_W-1:0]    way;
    logic [PROOF_W-1:0]  new_proof;
    logic [PROOF_W-1:0]  new_disproof;
    logic [DIST_W-1:0]   new_distance;
    logic [VISITS_W-1:0] new_visits;
  } item_t;

  typedef struct packed {
    outcome_e            outcome;
    logic [WAY_W-1:0]    hit_way;
    logic [PROOF_W-1:0]  proof;
    logic [PROOF_W-1:0]  disproof;
    logic [DIST_W-1:0]   distance;
    logic [VISITS_W-1:0] visits;
  } result_t;

endpackage

### sv/set_assoc_table_age_replace.sv
// Top level of the three-way set-associative result table with age-based replacement.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o   action, key, way, new_* fields
//   out      output     out_valid_o / out_ready_i outcome, hit_way, proof, disproof,
//                                                 distance, visits
//   cfg      input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// Each transaction first reads the set row from the table memory, then updates it
// and writes it back, so one item is in flight at a time.
// After reset a clearing pass writes every one of the 65536 set rows, during which
// no input transaction is accepted.
// A finished result waits in the output register; a stalled output holds the
// update cycle and its write-back until the register is free, and no new input
// transaction is taken until then.
`timescale 1ns / 1ps
module set_assoc_table_age_replace (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sata_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sata_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic [sata_pkg::KEY_W-1:0]        key_i,
  input  logic [sata_pkg::WAY_W-1:0]        way_i,
  input  logic [sata_pkg::PROOF_W-1:0]      new_proof_i,
  input  logic [sata_pkg::PROOF_W-1:0]      new_disproof_i,
  input  logic [sata_pkg::DIST_W-1:0]       new_distance_i,
  input  logic [sata_pkg::VISITS_W-1:0]     new_visits_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        outcome_o,
  output logic [sata_pkg::WAY_W-1:0]        hit_way_o,
  output logic [sata_pkg::PROOF_W-1:0]      proof_o,
  output logic [sata_pkg::PROOF_W-1:0]      disproof_o,
  output logic [sata_pkg::DIST_W-1:0]       distance_o,
  output logic [sata_pkg::VISITS_W-1:0]     visits_o
);

  import sata_pkg::*;

  state_e             state_q, state_d;
  logic [SET_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [MASK_W-1:0]  mask_q;
  logic [GEN_W-1:0]   gen_q;
  item_t              item_q;
  logic [SET_W-1:0]   set_q;
  logic               out_valid_q, out_valid_d;
  result_t            res_q;

  logic               accept;
  logic               load_out;
  logic               out_free;
  logic [SET_W-1:0]   in_set;

  logic               ram_we;
  logic [SET_W-1:0]   ram_waddr;
  logic [ROW_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [ROW_W-1:0]   ram_rdata;

  row_t               upd_row;
  logic               upd_we;
  result_t            upd_res;

  assign in_set   = key_i[SET_W-1:0] & SET_W'(mask_q);
  assign out_free = !out_valid_q || out_ready_i;

  sata_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_set),
    .rdata_o (ram_rdata)
  );

  sata_lookup u_lookup (
    .row_i    (row_t'(ram_rdata)),
    .item_i   (item_q),
    .gen_i    (gen_q),
    .row_o    (upd_row),
    .we_o     (upd_we),
    .result_o (upd_res)
  );

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    load_out   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = set_q;
    ram_wdata  = ROW_W'(upd_row);
    ram_re     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          accept  = 1'b1;
          ram_re  = 1'b1;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          load_out = 1'b1;
          ram_we   = upd_we;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      mask_q      <= '1;
      gen_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == CFG_INDEX_MASK) begin
        mask_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_GENERATION) begin
        gen_q <= cfg_data_i[GEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action       <= action_e'(action_i);
      item_q.tag          <= key_i[KEY_W-1:KEY_W-TAG_W];
      item_q.way          <= way_i;
      item_q.new_proof    <= new_proof_i;
      item_q.new_disproof <= new_disproof_i;
      item_q.new_distance <= new_distance_i;
      item_q.new_visits   <= new_visits_i;
      set_q               <= in_set;
    end
    if (load_out) begin
      res_q <= upd_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o   = res_q.outcome;
  assign hit_way_o   = res_q.hit_way;
  assign proof_o     = res_q.proof;
  assign disproof_o  = res_q.disproof;
  assign distance_o  = res_q.distance;
  assign visits_o    = res_q.visits;

  // The table memory is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("table memory read and written in the same cycle");

  // A new result only ever appears after the update cycle of a lookup.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> $past(accept) || $past(state_q) == ST_LOOKUP)
    else $error("result loaded without a preceding read");

  // A write transaction always reports the write outcome.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && item_q.action == ACT_WRITE |=> outcome_o == OUT_WRITE)
    else $error("write transaction reported a lookup outcome");

  // No transaction is taken before the clearing pass has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> $past(state_q) != ST_CLEAR || $past(clr_cnt_q) == '1)
    else $error("transaction accepted during the clearing pass");

endmodule

### sv/sata_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module sata_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sata_lookup.sv
// Set update logic: tag match, empty-way fill, oldest-way victim choice and way write.
`timescale 1ns / 1ps
module sata_lookup (
  input  sata_pkg::row_t                  row_i,
  input  sata_pkg::item_t                 item_i,
  input  logic [sata_pkg::GEN_W-1:0]      gen_i,
  output sata_pkg::row_t                  row_o,
  output logic                            we_o,
  output sata_pkg::result_t               result_o
);

  import sata_pkg::*;

  logic             found;
  logic             is_empty;
  logic [WAY_W-1:0] sel;
  logic [WAY_W-1:0] best;
  logic [GEN_W-1:0] best_age;
  logic [GEN_W-1:0] cur_age;
  logic [WAY_W-1:0] target;
  logic             do_fill;
  logic             way_ok;

  always_comb begin
    found    = 1'b0;
    is_empty = 1'b0;
    sel      = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!found && (row_i[w].tag == '0 || row_i[w].tag == item_i.tag)) begin
        found    = 1'b1;
        sel      = WAY_W'(w);
        is_empty = (row_i[w].tag == '0);
      end
    end

    best     = '0;
    best_age = gen_i - row_i[0].age;
    cur_age  = best_age;
    for (int w = 1; w < WAY_COUNT; w++) begin
      cur_age = gen_i - row_i[w].age;
      if (cur_age > best_age) begin
        best     = WAY_W'(w);
        best_age = cur_age;
      end
    end

    target  = found ? sel : best;
    do_fill = !found || is_empty;
    way_ok  = ({1'b0, item_i.way} < WAY_LIMIT);

    row_o    = row_i;
    we_o     = 1'b0;
    result_o = '0;

    if (item_i.action == ACT_WRITE) begin
      result_o.outcome = OUT_WRITE;
      result_o.hit_way = item_i.way;
      if (way_ok) begin
        we_o              = 1'b1;
        result_o.proof    = item_i.new_proof;
        result_o.disproof = item_i.new_disproof;
        result_o.distance = item_i.new_distance;
        result_o.visits   = item_i.new_visits;
        for (int w = 0; w < WAY_COUNT; w++) begin
          if (WAY_W'(w) == item_i.way) begin
            row_o[w].proof    = item_i.new_proof;
            row_o[w].disproof = item_i.new_disproof;
            row_o[w].distance = item_i.new_distance;
            row_o[w].visits   = item_i.new_visits;
          end
        end
      end
    end else begin
      we_o             = 1'b1;
      result_o.hit_way = target;
      if (!found) begin
        result_o.outcome = OUT_REPLACE;
      end else if (is_empty) begin
        result_o.outcome = OUT_FILL;
      end else begin
        result_o.outcome = OUT_HIT;
      end
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (WAY_W'(w) == target) begin
          row_o[w].age = gen_i;
          if (do_fill) begin
            row_o[w].tag      = item_i.tag;
            row_o[w].proof    = DEFAULT_PROOF;
            row_o[w].disproof = DEFAULT_PROOF;
            row_o[w].distance = DEFAULT_DISTANCE;
            row_o[w].visits   = '0;
          end
          result_o.proof    = row_o[w].proof;
          result_o.disproof = row_o[w].disproof;
          result_o.distance = row_o[w].distance;
          result_o.visits   = row_o[w].visits;
        end
      end
    end
  end

endmodule

### test/testbench.sv
// Self-checking testbench for the three-way set-associative result table with age replacement.
`timescale 1ns / 1ps
module testbench;
  import sata_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_SLACK     = 4;
  localparam int unsigned PHASES          = 14;
  localparam int unsigned ITEMS_PER_PHASE = 50;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  localparam logic [TAG_W-1:0] TAG_A = 32'hA5A5_0001;
  localparam logic [TAG_W-1:0] TAG_B = 32'h5A5A_0002;
  localparam logic [TAG_W-1:0] TAG_C = 32'h0F0F_0003;
  localparam logic [TAG_W-1:0] TAG_D = 32'hF0F0_0004;
  localparam logic [TAG_W-1:0] TAG_E = 32'h1357_9BDF;
  localparam logic [TAG_W-1:0] TAG_F = 32'h8000_0000;
  localparam logic [31:0] LOW_SET5 = 32'h0000_0005;
  localparam logic [31:0] LOW_SET9 = 32'h0000_0009;

  localparam logic [MASK_W-1:0] PHASE_MASK [8] = '{16'hFFFF, 16'h0000, 16'h0003, 16'h0001,
                                                   16'h0007, 16'h0003, 16'hFFFF, 16'h000F};
  localparam logic [GEN_W-1:0] PHASE_GEN [8] = '{8'd255, 8'd0, 8'd1, 8'd2,
                                                 8'd130, 8'd4, 8'd254, 8'd255};

  typedef struct packed {
    action_e             action;
    logic [KEY_W-1:0]    key;
    logic [WAY_W-1:0]    way;
    logic [PROOF_W-1:0]  new_proof;
    logic [PROOF_W-1:0]  new_disproof;
    logic [DIST_W-1:0]   new_distance;
    logic [VISITS_W-1:0] new_visits;
  } probe_t;

  typedef struct packed {
    logic             set_gen;
    logic [GEN_W-1:0] gen;
    logic             typed;
    probe_t           probe;
    result_t          want;
  } directed_row_t;

  localparam result_t NO_CHECK = '0;

  localparam directed_row_t DIRECTED [20] = '{
    '{1'b0, 8'd0, 1'b1, '{ACT_LOOKUP, {TAG_A, LOW_SET5}, 2'd0, '0, '0, '0, '0},
      '{OUT_FILL, 2'd0, 27'd1, 27'd1, DEFAULT_DISTANCE, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_LOOKUP, {TAG_B, LOW_SET5}, 2'd0, '0, '0, '0, '0},
      '{OUT_FILL, 2'd1, 27'd1, 27'd1, DEFAULT_DISTANCE, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_LOOKUP, {TAG_A, LOW_SET5}, 2'd0, '0, '0, '0, '0},
      '{OUT_HIT, 2'd0, 27'd1, 27'd1, DEFAULT_DISTANCE, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_WRITE, {TAG_A, LOW_SET5}, 2'd0, 27'd100000000, 27'd100000000,
                          20'd1000000, 31'h7FFF_FFFF},
      '{OUT_WRITE, 2'd0, 27'd100000000, 27'd100000000, 20'd1000000, 31'h7FFF_FFFF}},
    '{1'b0, 8'd0, 1'b1, '{ACT_LOOKUP, {TAG_A, LOW_SET5}, 2'd0, '0, '0, '0, '0},
      '{OUT_HIT, 2'd0, 27'd100000000, 27'd100000000, 20'd1000000, 31'h7FFF_FFFF}},
    '{1'b0, 8'd0, 1'b1, '{ACT_WRITE, {TAG_A, LOW_SET5}, 2'd3, 27'd100000000, 27'd100000000,
                          20'd1000000, 31'h7FFF_FFFF},
      '{OUT_WRITE, 2'd3, 27'd0, 27'd0, 20'd0, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_WRITE, {TAG_C, LOW_SET5}, 2'd2, 27'd12345, 27'd54321,
                          20'd777, 31'd99},
      '{OUT_WRITE, 2'd2, 27'd12345, 27'd54321, 20'd777, 31'd99}},
    '{1'b0, 8'd0, 1'b1, '{ACT_LOOKUP, {TAG_C, LOW_SET5}, 2'd0, '0, '0, '0, '0},
      '{OUT_FILL, 2'd2, 27'd1, 27'd1, DEFAULT_DISTANCE, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_LOOKUP, {TAG_D, LOW_SET5}, 2'd0, '0, '0, '0, '0},
      '{OUT_REPLACE, 2'd0, 27'd1, 27'd1, DEFAULT_DISTANCE, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_LOOKUP, {32'd0, LOW_SET9}, 2'd0, '0, '0, '0, '0},
      '{OUT_FILL, 2'd0, 27'd1, 27'd1, DEFAULT_DISTANCE, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_LOOKUP, {32'd0, LOW_SET9}, 2'd0, '0, '0, '0, '0},
      '{OUT_FILL, 2'd0, 27'd1, 27'd1, DEFAULT_DISTANCE, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_WRITE, {32'd0, LOW_SET9}, 2'd1, '0, '0, '0, '0},
      '{OUT_WRITE, 2'd1, 27'd0, 27'd0, 20'd0, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 2'd0, '0, '0, '0, '0},
      '{OUT_FILL, 2'd0, 27'd1, 27'd1, DEFAULT_DISTANCE, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_LOOKUP, 64'd0, 2'd0, '0, '0, '0, '0},
      '{OUT_FILL, 2'd0, 27'd1, 27'd1, DEFAULT_DISTANCE, 31'd0}},
    '{1'b0, 8'd0, 1'b1, '{ACT_WRITE, 64'd0, 2'd0, 27'd1, 27'd2, 20'd3, 31'd4},
      '{OUT_WRITE, 2'd0, 27'd1, 27'd2, 20'd3, 31'd4}},
    '{1'b1, 8'd255, 1'b0, '{ACT_LOOKUP, {TAG_B, LOW_SET5}, 2'd0, '0, '0, '0, '0}, NO_CHECK},
    '{1'b1, 8'd3, 1'b0, '{ACT_LOOKUP, {TAG_E, LOW_SET5}, 2'd0, '0, '0, '0, '0}, NO_CHECK},
    '{1'b0, 8'd0, 1'b0, '{ACT_LOOKUP, {TAG_D, LOW_SET5}, 2'd0, '0, '0, '0, '0}, NO_CHECK},
    '{1'b0, 8'd0, 1'b0, '{ACT_WRITE, {TAG_E, 32'hFFFF_0005}, 2'd1, 27'd99999999, 27'd1,
                          20'd999999, 31'd1}, NO_CHECK},
    '{1'b0, 8'd0, 1'b0, '{ACT_LOOKUP, {TAG_F, 32'h0001_0005}, 2'd0, '0, '0, '0, '0}, NO_CHECK}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  action_i;
  logic [KEY_W-1:0]      key_i;
  logic [WAY_W-1:0]      way_i;
  logic [PROOF_W-1:0]    new_proof_i;
  logic [PROOF_W-1:0]    new_disproof_i;
  logic [DIST_W-1:0]     new_distance_i;
  logic [VISITS_W-1:0]   new_visits_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            outcome_o;
  logic [WAY_W-1:0]      hit_way_o;
  logic [PROOF_W-1:0]    proof_o;
  logic [PROOF_W-1:0]    disproof_o;
  logic [DIST_W-1:0]     distance_o;
  logic [VISITS_W-1:0]   visits_o;

  bit [TAG_W-1:0]    tag_mem      [int unsigned];
  bit [GEN_W-1:0]    age_mem      [int unsigned];
  bit [PROOF_W-1:0]  proof_mem    [int unsigned];
  bit [PROOF_W-1:0]  disproof_mem [int unsigned];
  bit [DIST_W-1:0]   distance_mem [int unsigned];
  bit [VISITS_W-1:0] visits_mem   [int unsigned];

  logic [MASK_W-1:0] index_mask = 16'hFFFF;
  logic [GEN_W-1:0]  generation = 8'd0;
  logic [TAG_W-1:0]  tag_pool [8];

  result_t     pending_results [$];
  int unsigned mismatches = 0;
  bit          hold_req = 1'b0;
  bit          free_run = 1'b0;

  set_assoc_table_age_replace DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .key_i          (key_i),
    .way_i          (way_i),
    .new_proof_i    (new_proof_i),
    .new_disproof_i (new_disproof_i),
    .new_distance_i (new_distance_i),
    .new_visits_i   (new_visits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .outcome_o      (outcome_o),
    .hit_way_o      (hit_way_o),
    .proof_o        (proof_o),
    .disproof_o     (disproof_o),
    .distance_o     (distance_o),
    .visits_o       (visits_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void fill_entry(int unsigned entry, logic [TAG_W-1:0] tag);
    tag_mem[entry]      = tag;
    age_mem[entry]      = generation;
    proof_mem[entry]    = DEFAULT_PROOF;
    disproof_mem[entry] = DEFAULT_PROOF;
    distance_mem[entry] = DEFAULT_DISTANCE;
    visits_mem[entry]   = '0;
  endfunction

  function automatic result_t probe_table(probe_t p);
    int unsigned base;
    int unsigned entry;
    int unsigned w;
    int unsigned oldest_way;
    bit [GEN_W-1:0] span;
    bit [GEN_W-1:0] oldest_span;
    logic [TAG_W-1:0] tag;
    bit found;
    result_t r;
    base  = (int'(p.key[MASK_W-1:0] & index_mask) % SET_COUNT) * WAY_COUNT;
    tag   = p.key[KEY_W-1:KEY_W-TAG_W];
    r     = '0;
    entry = base;
    r.outcome = OUT_WRITE;
    r.hit_way = p.way;
    if (p.action == ACT_WRITE) begin
      if (p.way >= WAY_COUNT) return r;
      entry = base + p.way;
      proof_mem[entry]    = p.new_proof;
      disproof_mem[entry] = p.new_disproof;
      distance_mem[entry] = p.new_distance;
      visits_mem[entry]   = p.new_visits;
    end else begin
      found = 1'b0;
      for (w = 0; w < WAY_COUNT && !found; w++) begin
        entry = base + w;
        if (tag_mem[entry] == '0) begin
          found = 1'b1;
          r.outcome = OUT_FILL;
          r.hit_way = WAY_W'(w);
          fill_entry(entry, tag);
        end else if (tag_mem[entry] == tag) begin
          found = 1'b1;
          r.outcome = OUT_HIT;
          r.hit_way = WAY_W'(w);
          age_mem[entry] = generation;
        end
      end
      if (!found) begin
        oldest_way  = 0;
        oldest_span = '0;
        for (w = 0; w < WAY_COUNT; w++) begin
          span = generation - age_mem[base + w];
          if (w == 0 || span > oldest_span) begin
            oldest_way  = w;
            oldest_span = span;
          end
        end
        entry = base + oldest_way;
        fill_entry(entry, tag);
        r.outcome = OUT_REPLACE;
        r.hit_way = WAY_W'(oldest_way);
      end
    end
    r.proof    = proof_mem[entry];
    r.disproof = disproof_mem[entry];
    r.distance = distance_mem[entry];
    r.visits   = visits_mem[entry];
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (free_run || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic probe_t random_probe();
    probe_t p;
    int unsigned r;
    p.action = ($urandom_range(0, 99) < 65) ? ACT_LOOKUP : ACT_WRITE;
    p.key[31:16] = 16'($urandom);
    p.key[15:0]  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 5) begin
      p.key[63:32] = '0;
    end else if (r < 12) begin
      p.key[63:32] = $urandom;
    end else begin
      p.key[63:32] = tag_pool[$urandom_range(0, 7)];
    end
    p.way          = ($urandom_range(0, 9) == 0) ? WAY_W'(WAY_COUNT) : WAY_W'($urandom_range(0, 2));
    p.new_proof    = PROOF_W'($urandom_range(0, 100000000));
    p.new_disproof = PROOF_W'($urandom_range(0, 100000000));
    p.new_distance = DIST_W'($urandom_range(0, 1000000));
    p.new_visits   = VISITS_W'($urandom);
    return p;
  endfunction

  task automatic offer(probe_t p, logic typed, result_t want);
    result_t predicted;
    int unsigned gap;
    in_valid_i     <= 1'b1;
    action_i       <= p.action;
    key_i          <= p.key;
    way_i          <= p.way;
    new_proof_i    <= p.new_proof;
    new_disproof_i <= p.new_disproof;
    new_distance_i <= p.new_distance;
    new_visits_i   <= p.new_visits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = probe_table(p);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic set_config(logic [MASK_W-1:0] mask, logic [GEN_W-1:0] gen);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_INDEX_MASK;
    cfg_data_i <= mask;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GENERATION;
    cfg_data_i <= {8'($urandom), gen};
    @(posedge clk_i);
    cfg_idx_i  <= $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
    cfg_data_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    index_mask = mask;
    generation = gen;
  endtask

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, outcome %0d, way %0d", $time, outcome_o,
                 hit_way_o);
      end else begin
        want = pending_results.pop_front();
        report_field("outcome", want.outcome, outcome_o);
        report_field("hit_way", want.hit_way, hit_way_o);
        report_field("proof", want.proof, proof_o);
        report_field("disproof", want.disproof, disproof_o);
        report_field("distance", want.distance, distance_o);
        report_field("visits", want.visits, visits_o);
      end
    end
  end

  initial begin : receiver
    int unsigned n;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (!free_run && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        n = idle_len() + 1;
      end else begin
        out_ready_i <= 1'b1;
        n = $urandom_range(1, 6);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned ph;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    action_i       = 1'b0;
    key_i          = '0;
    way_i          = '0;
    new_proof_i    = '0;
    new_disproof_i = '0;
    new_distance_i = '0;
    new_visits_i   = '0;
    for (i = 0; i < 8; i++) tag_pool[i] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].set_gen) begin
        settle();
        set_config(index_mask, DIRECTED[i].gen);
      end
      offer(DIRECTED[i].probe, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      set_config(PHASE_MASK[ph % 8], (ph < 8) ? PHASE_GEN[ph] : GEN_W'($urandom));
      free_run = (ph == 2 || ph == 9);
      tag_pool[$urandom_range(0, 7)] = $urandom;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 3 && i == 10) hold_req = 1'b1;
        if (ph == 5 && i == 25) settle();
        offer(random_probe(), 1'b0, NO_CHECK);
      end
    end
    free_run = 1'b0;

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
